// File: hdl/nrmc_pkg.sv
// types, character codes and constants shared by the rmc sentence parser
`default_nettype none

package nrmc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] code;
        logic       is_dollar;
        logic       is_eol;
        logic       is_comma;
        logic       is_point;
        logic       is_digit;
        logic [3:0] digit;
    } char_info_t;

    typedef logic [2:0][6:0] pair_word_t;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_COMMA  = 8'h2c;
    localparam logic [7:0] CHAR_POINT  = 8'h2e;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_N      = 8'h4e;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4d;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_E      = 8'h45;

    localparam logic [3:0] FIELD_TIME     = 4'd1;
    localparam logic [3:0] FIELD_LAT      = 4'd3;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd4;
    localparam logic [3:0] FIELD_LON      = 4'd5;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd6;
    localparam logic [3:0] FIELD_DATE     = 4'd9;
    localparam logic [3:0] FIELD_LAST     = 4'd15;
    localparam logic [3:0] DIGIT_IDX_LAST = 4'd15;
    localparam logic [3:0] PAIR_CHARS     = 4'd6;

    localparam logic [2:0] HDR_FIRST = 3'd1;
    localparam logic [2:0] HDR_LAST  = 3'd5;
    localparam logic [7:0] HDR_COUNT = 8'd6;

    localparam logic [2:0]  NUM_ENDED = 3'd7;
    localparam logic [27:0] LAT_MAX   = 28'h7ffffff;
    localparam logic [27:0] LON_MAX   = 28'hfffffff;
    localparam logic [11:0] YEAR_BASE = 12'd2000;
    localparam logic [11:0] YEAR_LAST = 12'd2099;
    localparam logic [6:0]  PAIR_MAX  = 7'd99;

    function automatic logic [19:0] pow10(input logic [2:0] k);
        logic [19:0] r;
        case (k)
            3'd0: r = 20'd1;
            3'd1: r = 20'd10;
            3'd2: r = 20'd100;
            3'd3: r = 20'd1000;
            3'd4: r = 20'd10000;
            3'd5: r = 20'd100000;
            3'd6: r = 20'd1000000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/nrmc_front.sv
// front end: character classification and two-entry queue to the parser
`default_nettype none

module nrmc_front
    import nrmc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    output logic            q_valid,
    output char_info_t      q_info,
    input  wire logic       q_pop
);

    char_info_t info_in;
    char_info_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    always_comb begin
        info_in.code      = s_char_in;
        info_in.is_dollar = (s_char_in == CHAR_DOLLAR);
        info_in.is_eol    = (s_char_in == CHAR_CR) || (s_char_in == CHAR_LF);
        info_in.is_comma  = (s_char_in == CHAR_COMMA);
        info_in.is_point  = (s_char_in == CHAR_POINT);
        info_in.is_digit  = (s_char_in >= CHAR_ZERO) && (s_char_in <= CHAR_NINE);
        info_in.digit     = 4'(s_char_in - CHAR_ZERO);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_info  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= info_in;
        end
    end

endmodule

`default_nettype wire

// File: hdl/nrmc_back.sv
// back end: sentence state machine, field extraction and result register
`default_nettype none

module nrmc_back
    import nrmc_pkg::*;
#(
    parameter int MAX_SENTENCE_CHARS = 128,
    parameter int FRAC_DIGITS        = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire char_info_t   q_info,
    output logic              q_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [6:0]        m_hour,
    output logic [6:0]        m_minute,
    output logic [6:0]        m_second,
    output logic [6:0]        m_day,
    output logic [6:0]        m_month,
    output logic [11:0]       m_year,
    output logic signed [27:0] m_latitude,
    output logic signed [28:0] m_longitude,
    output logic              m_complete
);

    localparam logic [7:0]  MAX_CHARS  = 8'(MAX_SENTENCE_CHARS);
    localparam logic [2:0]  FRAC_LIMIT = 3'(FRAC_DIGITS);
    localparam logic [19:0] INT_SCALE  = pow10(3'(FRAC_DIGITS));

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [3:0]  field_reg, field_next;
    logic [3:0]  digit_idx_reg, digit_idx_next;
    logic [7:0]  char_cnt_reg, char_cnt_next;
    pair_word_t  time_reg, time_next;
    pair_word_t  date_reg, date_next;
    logic [26:0] lat_acc_reg, lat_acc_next;
    logic [27:0] lon_acc_reg, lon_acc_next;
    logic [2:0]  frac_cnt_reg, frac_cnt_next;
    logic        point_reg, point_next;
    logic        lat_pos_reg, lat_pos_next;
    logic        lon_pos_reg, lon_pos_next;

    logic        m_valid_reg;
    logic [6:0]  hour_reg, minute_reg, second_reg, day_reg, month_reg;
    logic [11:0] year_reg;
    logic [27:0] lat_out_reg;
    logic [28:0] lon_out_reg;
    logic        complete_reg;

    logic        emit;
    logic        load;
    logic        hdr_ok;

    // shared pair and coordinate datapath
    pair_word_t  pair_in, pair_out;
    logic [1:0]  pair_sel;
    logic [10:0] pair_mac;
    logic [27:0] acc_sel, max_sel, acc_out;
    logic [2:0]  frac_out;
    logic [2:0]  frac_idx;
    logic [19:0] scale;
    logic [23:0] prod;
    logic [32:0] base, sum;
    logic        point_pair, point_coord;

    assign emit  = q_info.is_eol && !q_info.is_dollar && (phase_reg == PH_BODY);
    assign q_pop = q_valid && (!emit || !m_valid_reg || m_ready);
    assign load  = q_pop && emit;

    always_comb begin
        case (hdr_idx_reg)
            3'd1: hdr_ok = (q_info.code == CHAR_G);
            3'd2: hdr_ok = (q_info.code == CHAR_P) || (q_info.code == CHAR_N);
            3'd3: hdr_ok = (q_info.code == CHAR_R);
            3'd4: hdr_ok = (q_info.code == CHAR_M);
            3'd5: hdr_ok = (q_info.code == CHAR_C);
            default: hdr_ok = 1'b0;
        endcase
    end

    // digit pairs for time and date
    always_comb begin
        pair_in    = (field_reg == FIELD_TIME) ? time_reg : date_reg;
        pair_out   = pair_in;
        point_pair = point_reg;
        pair_sel   = 2'd2 - digit_idx_reg[2:1];
        pair_mac   = {1'b0, pair_in[pair_sel], 3'b000} + {3'b000, pair_in[pair_sel], 1'b0}
                   + {7'd0, q_info.digit};
        if (digit_idx_reg < PAIR_CHARS) begin
            if (!digit_idx_reg[0]) begin
                point_pair         = !q_info.is_digit;
                pair_out[pair_sel] = q_info.is_digit ? {3'b000, q_info.digit} : 7'd0;
            end else if (!point_reg && q_info.is_digit) begin
                pair_out[pair_sel] = pair_mac[6:0];
            end
        end
    end

    // position number, latitude or longitude
    always_comb begin
        acc_sel     = (field_reg == FIELD_LAT) ? {1'b0, lat_acc_reg} : lon_acc_reg;
        max_sel     = (field_reg == FIELD_LAT) ? LAT_MAX : LON_MAX;
        frac_idx    = FRAC_LIMIT - 3'd1 - frac_cnt_reg;
        scale       = point_reg ? pow10(frac_idx) : INT_SCALE;
        base        = point_reg ? {5'd0, acc_sel}
                                : ({2'b00, acc_sel, 3'b000} + {4'b0000, acc_sel, 1'b0});
        prod        = {20'd0, q_info.digit} * {4'd0, scale};
        sum         = base + {9'd0, prod};
        acc_out     = acc_sel;
        frac_out    = frac_cnt_reg;
        point_coord = point_reg;
        if (frac_cnt_reg != NUM_ENDED) begin
            if (q_info.is_digit) begin
                if (!point_reg || frac_cnt_reg < FRAC_LIMIT) begin
                    acc_out = (sum > {5'd0, max_sel}) ? max_sel : sum[27:0];
                end
                if (point_reg && frac_cnt_reg < FRAC_LIMIT) begin
                    frac_out = frac_cnt_reg + 3'd1;
                end
            end else if (q_info.is_point && !point_reg) begin
                point_coord = 1'b1;
            end else begin
                frac_out = NUM_ENDED;
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        field_next     = field_reg;
        digit_idx_next = digit_idx_reg;
        char_cnt_next  = char_cnt_reg;
        time_next      = time_reg;
        date_next      = date_reg;
        lat_acc_next   = lat_acc_reg;
        lon_acc_next   = lon_acc_reg;
        frac_cnt_next  = frac_cnt_reg;
        point_next     = point_reg;
        lat_pos_next   = lat_pos_reg;
        lon_pos_next   = lon_pos_reg;
        if (q_pop) begin
            if (q_info.is_dollar) begin
                phase_next   = PH_HEADER;
                hdr_idx_next = HDR_FIRST;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (!hdr_ok || q_info.is_eol) begin
                            phase_next   = PH_IDLE;
                            hdr_idx_next = 3'd0;
                        end else if (hdr_idx_reg == HDR_LAST) begin
                            phase_next     = PH_BODY;
                            hdr_idx_next   = 3'd0;
                            field_next     = 4'd0;
                            digit_idx_next = 4'd0;
                            char_cnt_next  = HDR_COUNT;
                            time_next      = '0;
                            date_next      = '0;
                            lat_acc_next   = '0;
                            lon_acc_next   = '0;
                            frac_cnt_next  = 3'd0;
                            point_next     = 1'b0;
                            lat_pos_next   = 1'b0;
                            lon_pos_next   = 1'b0;
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 3'd1;
                        end
                    end
                    PH_BODY: begin
                        if (q_info.is_eol || char_cnt_reg >= MAX_CHARS) begin
                            phase_next = PH_IDLE;
                        end else begin
                            char_cnt_next = char_cnt_reg + 8'd1;
                            if (q_info.is_comma) begin
                                if (field_reg != FIELD_LAST) begin
                                    field_next = field_reg + 4'd1;
                                end
                                digit_idx_next = 4'd0;
                                point_next     = 1'b0;
                                frac_cnt_next  = 3'd0;
                            end else begin
                                case (field_reg)
                                    FIELD_TIME: begin
                                        time_next  = pair_out;
                                        point_next = point_pair;
                                    end
                                    FIELD_DATE: begin
                                        date_next  = pair_out;
                                        point_next = point_pair;
                                    end
                                    FIELD_LAT: begin
                                        lat_acc_next  = acc_out[26:0];
                                        frac_cnt_next = frac_out;
                                        point_next    = point_coord;
                                    end
                                    FIELD_LON: begin
                                        lon_acc_next  = acc_out;
                                        frac_cnt_next = frac_out;
                                        point_next    = point_coord;
                                    end
                                    FIELD_LAT_HEMI: begin
                                        if (digit_idx_reg == 4'd0) begin
                                            lat_pos_next = (q_info.code == CHAR_N);
                                        end
                                    end
                                    FIELD_LON_HEMI: begin
                                        if (digit_idx_reg == 4'd0) begin
                                            lon_pos_next = (q_info.code == CHAR_E);
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                if (digit_idx_reg != DIGIT_IDX_LAST) begin
                                    digit_idx_next = digit_idx_reg + 4'd1;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            hdr_idx_reg   <= 3'd0;
            field_reg     <= 4'd0;
            digit_idx_reg <= 4'd0;
            char_cnt_reg  <= 8'd0;
            time_reg      <= '0;
            date_reg      <= '0;
            lat_acc_reg   <= '0;
            lon_acc_reg   <= '0;
            frac_cnt_reg  <= 3'd0;
            point_reg     <= 1'b0;
            lat_pos_reg   <= 1'b0;
            lon_pos_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            field_reg     <= field_next;
            digit_idx_reg <= digit_idx_next;
            char_cnt_reg  <= char_cnt_next;
            time_reg      <= time_next;
            date_reg      <= date_next;
            lat_acc_reg   <= lat_acc_next;
            lon_acc_reg   <= lon_acc_next;
            frac_cnt_reg  <= frac_cnt_next;
            point_reg     <= point_next;
            lat_pos_reg   <= lat_pos_next;
            lon_pos_reg   <= lon_pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hour_reg     <= time_reg[2];
            minute_reg   <= time_reg[1];
            second_reg   <= time_reg[0];
            day_reg      <= date_reg[2];
            month_reg    <= date_reg[1];
            year_reg     <= YEAR_BASE + {5'd0, date_reg[0]};
            lat_out_reg  <= lat_pos_reg ? {1'b0, lat_acc_reg} : (28'd0 - {1'b0, lat_acc_reg});
            lon_out_reg  <= lon_pos_reg ? {1'b0, lon_acc_reg} : (29'd0 - {1'b0, lon_acc_reg});
            complete_reg <= (field_reg >= FIELD_DATE);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hour      = hour_reg;
    assign m_minute    = minute_reg;
    assign m_second    = second_reg;
    assign m_day       = day_reg;
    assign m_month     = month_reg;
    assign m_year      = year_reg;
    assign m_latitude  = signed'(lat_out_reg);
    assign m_longitude = signed'(lon_out_reg);
    assign m_complete  = complete_reg;

endmodule

`default_nettype wire

// File: hdl/nmea_rmc_sentence_parser.sv
// rmc sentence parser top level: front queue and parsing back end
// m_valid rises after the line-end character passes the queue slot and loads the result register
// throughput: one character per cycle unless a line end waits on m_ready behind a held result
// the two-entry queue keeps input flowing while a result waits on m_ready
// synchronous active-low reset empties the queue, drops the result and returns to idle
`default_nettype none

module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
#(
    parameter int MAX_SENTENCE_CHARS = 128,
    parameter int FRAC_DIGITS        = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_char_in,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [6:0]         m_hour,
    output logic [6:0]         m_minute,
    output logic [6:0]         m_second,
    output logic [6:0]         m_day,
    output logic [6:0]         m_month,
    output logic [11:0]        m_year,
    output logic signed [27:0] m_latitude,
    output logic signed [28:0] m_longitude,
    output logic               m_complete
);

    logic       q_valid;
    logic       q_pop;
    char_info_t q_info;

    nrmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .q_valid   (q_valid),
        .q_info    (q_info),
        .q_pop     (q_pop)
    );

    nrmc_back #(
        .MAX_SENTENCE_CHARS (MAX_SENTENCE_CHARS),
        .FRAC_DIGITS        (FRAC_DIGITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_info      (q_info),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hour      (m_hour),
        .m_minute    (m_minute),
        .m_second    (m_second),
        .m_day       (m_day),
        .m_month     (m_month),
        .m_year      (m_year),
        .m_latitude  (m_latitude),
        .m_longitude (m_longitude),
        .m_complete  (m_complete)
    );

endmodule

`default_nettype wire

// File: hdl/nrmc_checker.sv
// port-level checks on the rmc sentence parser and their bind
`default_nettype none

module nrmc_checker
    import nrmc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_char_in,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [6:0]  m_hour,
    input wire logic [6:0]  m_minute,
    input wire logic [6:0]  m_second,
    input wire logic [6:0]  m_day,
    input wire logic [6:0]  m_month,
    input wire logic [11:0] m_year,
    input wire logic [27:0] m_latitude,
    input wire logic [28:0] m_longitude,
    input wire logic        m_complete
);

    // no result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting input transaction holds its character
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_in))
        else $error("waiting input changed");

    // a stalled transaction keeps its coordinates, year, hour and complete flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_latitude) && $stable(m_longitude)
            && $stable(m_year) && $stable(m_complete) && $stable(m_hour))
        else $error("stalled result changed");

    // year always carries the century offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_year >= YEAR_BASE && m_year <= YEAR_LAST)
        else $error("year out of range");

    // two-digit pairs never exceed 99
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hour <= PAIR_MAX && m_minute <= PAIR_MAX && m_second <= PAIR_MAX
            && m_day <= PAIR_MAX && m_month <= PAIR_MAX)
        else $error("digit pair out of range");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);

`default_nettype wire

// File: tb/sv/tb_rmc_scoreboard_pkg.sv
// scoreboard for the rmc sentence parser: per-character predictor and result checker
package tb_rmc_scoreboard_pkg;

    import nrmc_pkg::*;

    localparam int SENT_MAX = 128;
    localparam int FRAC     = 4;

    localparam logic [7:0] HDR_CHARS [1:5] = '{CHAR_G, CHAR_P, CHAR_R, CHAR_M, CHAR_C};

    typedef struct packed {
        logic [6:0]         hour;
        logic [6:0]         minute;
        logic [6:0]         second;
        logic [6:0]         day;
        logic [6:0]         month;
        logic [11:0]        year;
        logic signed [27:0] latitude;
        logic signed [28:0] longitude;
        logic               complete;
    } rmc_fix_t;

    class rmc_scoreboard;

        phase_t     phase;
        logic [2:0] hdr_idx;
        logic [3:0] field_no;
        logic [3:0] char_idx;
        logic [7:0] sent_len;
        pair_word_t time_w;
        pair_word_t date_w;
        logic [27:0] lat_mag;
        logic [27:0] lon_mag;
        logic [2:0] frac_cnt;
        logic       after_point;
        logic       lat_north;
        logic       lon_east;

        rmc_fix_t pending_fixes[$];
        int n_chars;
        int n_predicted;
        int n_fixes;
        int n_complete;
        int n_fail;

        function new();
            phase   = PH_IDLE;
            hdr_idx = '0;
            clear_body();
        endfunction

        function void clear_body();
            field_no    = '0;
            char_idx    = '0;
            sent_len    = '0;
            time_w      = '0;
            date_w      = '0;
            lat_mag     = '0;
            lon_mag     = '0;
            frac_cnt    = '0;
            after_point = 1'b0;
            lat_north   = 1'b0;
            lon_east    = 1'b0;
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function longint unsigned ten_to(int k);
            longint unsigned r = 1;
            repeat (k) r = r * 10;
            return r;
        endfunction

        // two-digit groups of the time and date fields, first group in the top slot
        function pair_word_t pair_char(pair_word_t w, logic [3:0] pos, logic [7:0] c);
            int slot;
            int v;
            if (pos >= PAIR_CHARS) return w;
            slot = 2 - int'(pos[2:1]);
            if (!pos[0]) begin
                after_point = !is_num(c);
                w[slot] = is_num(c) ? 7'(c - CHAR_ZERO) : 7'd0;
            end else if (!after_point && is_num(c)) begin
                v = int'(w[slot]) * 10 + int'(c - CHAR_ZERO);
                w[slot] = 7'(v);
            end
            return w;
        endfunction

        function logic [27:0] coord_char(logic [27:0] acc, logic [7:0] c, logic [27:0] top);
            longint unsigned v = acc;
            longint unsigned d = c - CHAR_ZERO;
            if (frac_cnt == NUM_ENDED) return acc;
            if (is_num(c)) begin
                if (!after_point) begin
                    v = v * 10 + d * ten_to(FRAC);
                end else if (frac_cnt < FRAC) begin
                    frac_cnt++;
                    v = v + d * ten_to(FRAC - int'(frac_cnt));
                end
            end else if (c == CHAR_POINT && !after_point) begin
                after_point = 1'b1;
            end else begin
                frac_cnt = NUM_ENDED;
            end
            return (v > top) ? top : v[27:0];
        endfunction

        function void note_char(logic [7:0] c);
            bit eol = (c == CHAR_CR || c == CHAR_LF);
            bit ok;
            rmc_fix_t f;
            n_chars++;
            if (c == CHAR_DOLLAR) begin
                phase   = PH_HEADER;
                hdr_idx = HDR_FIRST;
                return;
            end
            if (phase == PH_IDLE) return;
            if (phase == PH_HEADER) begin
                ok = (c == HDR_CHARS[hdr_idx]) || (hdr_idx == HDR_FIRST + 1 && c == CHAR_N);
                if (!ok || eol) begin
                    phase   = PH_IDLE;
                    hdr_idx = '0;
                    return;
                end
                hdr_idx++;
                if (hdr_idx == HDR_LAST + 1) begin
                    clear_body();
                    sent_len = HDR_COUNT;
                    phase    = PH_BODY;
                    hdr_idx  = '0;
                end
                return;
            end
            if (eol) begin
                f.hour      = time_w[2];
                f.minute    = time_w[1];
                f.second    = time_w[0];
                f.day       = date_w[2];
                f.month     = date_w[1];
                f.year      = YEAR_BASE + date_w[0];
                f.latitude  = lat_north ? lat_mag : -lat_mag;
                f.longitude = lon_east ? {1'b0, lon_mag} : -{1'b0, lon_mag};
                f.complete  = (field_no >= FIELD_DATE);
                pending_fixes.push_back(f);
                n_predicted++;
                phase = PH_IDLE;
                clear_body();
                return;
            end
            // too long: sentence dropped without a result
            if (sent_len >= SENT_MAX) begin
                phase = PH_IDLE;
                clear_body();
                return;
            end
            sent_len++;
            if (c == CHAR_COMMA) begin
                if (field_no != FIELD_LAST) field_no++;
                char_idx    = '0;
                after_point = 1'b0;
                frac_cnt    = '0;
                return;
            end
            case (field_no)
                FIELD_TIME:     time_w = pair_char(time_w, char_idx, c);
                FIELD_LAT:      lat_mag = coord_char(lat_mag, c, LAT_MAX);
                FIELD_LAT_HEMI: if (char_idx == 0) lat_north = (c == CHAR_N);
                FIELD_LON:      lon_mag = coord_char(lon_mag, c, LON_MAX);
                FIELD_LON_HEMI: if (char_idx == 0) lon_east = (c == CHAR_E);
                FIELD_DATE:     date_w = pair_char(date_w, char_idx, c);
                default: ;
            endcase
            if (char_idx != DIGIT_IDX_LAST) char_idx++;
        endfunction

        function void compare_field(string fname, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", fname, want, got);
                n_fail++;
            end
        endfunction

        function void check_fix(rmc_fix_t got);
            rmc_fix_t want;
            if (pending_fixes.size() == 0) begin
                $error("result transaction with nothing expected: %0d:%0d:%0d lat %0d lon %0d",
                       got.hour, got.minute, got.second, got.latitude, got.longitude);
                n_fail++;
                return;
            end
            want = pending_fixes.pop_front();
            n_fixes++;
            if (got.complete) n_complete++;
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
            compare_field("day", want.day, got.day);
            compare_field("month", want.month, got.month);
            compare_field("year", want.year, got.year);
            compare_field("latitude", want.latitude, got.latitude);
            compare_field("longitude", want.longitude, got.longitude);
            compare_field("complete", want.complete, got.complete);
        endfunction

    endclass

endpackage

// File: tb/sv/tb_nmea_rmc_sentence_parser.sv
// top-level testbench of the rmc sentence parser: stimulus, handshakes and final verdict
module tb_nmea_rmc_sentence_parser;

    import nrmc_pkg::*;
    import tb_rmc_scoreboard_pkg::*;

    localparam int RAND_CHARS = 1050;
    localparam int RAND_FIXES = 12;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_in = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [6:0]         m_hour;
    logic [6:0]         m_minute;
    logic [6:0]         m_second;
    logic [6:0]         m_day;
    logic [6:0]         m_month;
    logic [11:0]        m_year;
    logic signed [27:0] m_latitude;
    logic signed [28:0] m_longitude;
    logic               m_complete;

    rmc_scoreboard sb = new();

    logic [7:0] line_q[$];
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int n_sent         = 0;
    int n_lines        = 0;

    nmea_rmc_sentence_parser dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $error("timeout with %0d results outstanding", sb.pending_fixes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_char_in);
            if (m_valid && m_ready)
                sb.check_fix({m_hour, m_minute, m_second, m_day, m_month, m_year,
                              m_latitude, m_longitude, m_complete});
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_char(line_q[i]);
        line_q.delete();
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CHAR_ZERO + $urandom_range(9));
    endfunction

    // printable, never a dollar or a comma
    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126)); while (c == CHAR_DOLLAR || c == CHAR_COMMA);
        return c;
    endfunction

    function automatic void put_text(string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endfunction

    function automatic void put_line(string s);
        put_text(s);
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
    endfunction

    function automatic void put_digits(int n);
        repeat (n) line_q.push_back(rand_digit());
    endfunction

    // body of exactly body_len characters after the header, padding in the speed field
    function automatic void put_padded(int body_len);
        int base = line_q.size();
        put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,");
        while (line_q.size() < base + int'(HDR_COUNT) + body_len - 8)
            line_q.push_back(rand_digit());
        put_line(",,230394");
    endfunction

    function automatic void put_pair_field();
        int r = $urandom_range(9);
        if (r < 7) begin
            put_digits(6);
            if (r < 3) begin
                line_q.push_back(CHAR_POINT);
                put_digits(2);
            end
        end else begin
            repeat ($urandom_range(0, 9))
                line_q.push_back($urandom_range(1) ? rand_digit() : rand_text_char());
        end
    endfunction

    function automatic void put_coord(int int_len);
        int n_int = ($urandom_range(9) == 0) ? $urandom_range(0, 10) : int_len;
        int r = $urandom_range(19);
        if (r == 0) line_q.push_back(rand_text_char());
        put_digits(n_int);
        if (r != 1) begin
            line_q.push_back(CHAR_POINT);
            put_digits($urandom_range(0, 7));
        end
        if (r == 2) begin
            line_q.push_back(CHAR_POINT);
            put_digits(2);
        end
        if (r == 3) begin
            put_text("-");
            put_digits(2);
        end
    endfunction

    function automatic void put_hemi(logic [7:0] good, logic [7:0] other);
        int r = $urandom_range(9);
        if (r < 4) line_q.push_back(good);
        else if (r < 7) line_q.push_back(other);
        else if (r == 8) line_q.push_back(rand_text_char());
        else if (r == 9) begin
            line_q.push_back(good);
            line_q.push_back(rand_text_char());
        end
    endfunction

    function automatic void build_random_sentence();
        int shape = $urandom_range(99);
        int cut   = $urandom_range(0, 11);
        int r;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
        put_text($urandom_range(1) ? "$GPRMC" : "$GNRMC");
        if (shape < 6) line_q[line_q.size() - 1 - $urandom_range(4)] = rand_text_char();
        for (int fld = 1; fld <= 12; fld++) begin
            if (shape >= 6 && shape < 16 && fld > cut) break;
            line_q.push_back(CHAR_COMMA);
            case (fld)
                FIELD_TIME, FIELD_DATE: put_pair_field();
                FIELD_LAT:      put_coord(4);
                FIELD_LAT_HEMI: put_hemi(CHAR_N, "S");
                FIELD_LON:      put_coord(5);
                FIELD_LON_HEMI: put_hemi(CHAR_E, "W");
                2:  put_text($urandom_range(1) ? "A" : "V");
                7:  put_digits((shape >= 16 && shape < 24) ? $urandom_range(40, 110)
                                                           : $urandom_range(0, 3));
                8:  put_digits($urandom_range(0, 4));
                12: begin
                    put_text("A*");
                    put_digits(2);
                end
                default: ;
            endcase
        end
        // cut off without a line end: the next dollar restarts the header
        if (shape >= 24 && shape < 30) begin
            r = $urandom_range(2, line_q.size() - 1);
            while (line_q.size() > r) void'(line_q.pop_back());
            return;
        end
        r = $urandom_range(3);
        if (r != 3) line_q.push_back(CHAR_CR);
        if (r != 2) line_q.push_back(CHAR_LF);
    endfunction

    initial begin
        int rand_from;
        int fix_from;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
        line_q.push_back(8'h00);
        line_q.push_back(8'hff);
        put_text("$GPX$X$GPRM");
        line_q.push_back(CHAR_CR);
        put_line("$GPRMC,235959.99,A,8959.9999,N,17959.9999,E,0.0,0.0,311299,,,A*00");
        put_line("$GNRMC,000000,V,0000.0000,S,00000.0000,W,,,010100,,,N*00");
        put_line("$GPRMC,12,A,1234.567891,N,12345.6789012,E,,,3112,,,A*00");
        put_line("$GPRMC,9a3b5c7890,A,999999999.9999,N,9999999999,E,,,a19,,,A*00");
        put_line("$GPRMC,a23456,A,12.34.56,,-123.4,e,,,1,,,A*00");
        put_line("$GPRMC,1234$GPRMC,010203,A,.5,Nx,00700.25,Ew,,,150620");
        put_line("$GPRMC,123456,A");
        put_line("$GPRMC,,,,,,,,,,,,,,,,,,,,,");
        put_text("$GPRMC,");
        line_q.push_back(8'hff);
        line_q.push_back(8'h00);
        put_line(",A,4807.038,N,01131.000,E,,,230394");
        put_padded(122);
        put_padded(123);
        send_line();

        rand_from = n_sent;
        fix_from  = sb.n_predicted;
        while (n_sent - rand_from < RAND_CHARS || sb.n_predicted - fix_from < RAND_FIXES) begin
            case ((n_lines / 4) % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            build_random_sentence();
            send_line();
            n_lines++;
        end
        s_valid <= 1'b0;

        while (sb.pending_fixes.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("%0d characters in %0d random sentences plus directed cases",
                 sb.n_chars, n_lines);
        $display("%0d results checked, %0d complete, %0d field mismatches",
                 sb.n_fixes, sb.n_complete, sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/nrmc_pkg.sv
hdl/nrmc_front.sv
hdl/nrmc_back.sv
hdl/nmea_rmc_sentence_parser.sv
hdl/nrmc_checker.sv
tb/sv/tb_rmc_scoreboard_pkg.sv
tb/sv/tb_nmea_rmc_sentence_parser.sv
